>>> sv/pflu_pkg.sv
// ----------------------------------------------------------------------------
// pflu_pkg
// Shared types and constants for the pixel feature lock update block.
// ----------------------------------------------------------------------------
package pflu_pkg;

  localparam int unsigned LvlW = 16;

  localparam logic [LvlW-1:0] ONE_Q15         = 16'd32768;
  localparam logic [LvlW-1:0] KEEP_MIN        = 16'd33;     // first level above 0.001
  localparam logic [LvlW-1:0] SPREAD_CEILING  = 16'd3277;
  localparam logic [LvlW-1:0] FIRST_GROW_STEP = 16'd8192;
  localparam logic [LvlW-1:0] COUNT_LIMIT     = 16'd255;

  localparam int unsigned InDataW  = 128;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_UNLOCK_LEVEL     = 3'd0,
    CFG_EDGE_FLOOR       = 3'd1,
    CFG_TRUST_FLOOR      = 3'd2,
    CFG_CHANGE_CEILING   = 3'd3,
    CFG_MOTION_CEILING   = 3'd4,
    CFG_FADE_STEP        = 3'd5,
    CFG_FORCED_FADE_STEP = 3'd6,
    CFG_GROW_STEP        = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [LvlW-1:0] unlock_level;
    logic [LvlW-1:0] edge_floor;
    logic [LvlW-1:0] trust_floor;
    logic [LvlW-1:0] change_ceiling;
    logic [LvlW-1:0] motion_ceiling;
    logic [LvlW-1:0] fade_step;
    logic [LvlW-1:0] forced_fade_step;
    logic [LvlW-1:0] grow_step;
  } cfg_t;

  typedef struct packed {
    logic                   clear_history;
    logic                   newly_uncovered;
    logic [LvlW-1:0]        reactivity;
    logic [LvlW-1:0]        prior_lock;
    logic [LvlW-1:0]        prior_count;
    logic [LvlW-1:0]        edge_level;
    logic [LvlW-1:0]        trust_level;
    logic signed [LvlW-1:0] brightness_change;
    logic [LvlW-1:0]        brightness_spread;
    logic signed [LvlW-1:0] motion_amount;
  } item_t;

  typedef struct packed {
    logic [LvlW-1:0] lock_level;
    logic [LvlW-1:0] lock_count;
  } res_t;

  // Saturate a Q1.15 value at 1.0.
  function automatic logic [LvlW-1:0] clamp_one(input logic [LvlW-1:0] v);
    clamp_one = (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

endpackage

>>> sv/pflu_cfg_regs.sv
// ----------------------------------------------------------------------------
// pflu_cfg_regs
// Configuration register file, write only, reset to the documented defaults.
// ----------------------------------------------------------------------------
module pflu_cfg_regs import pflu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [LvlW-1:0]    cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_UNLOCK_LEVEL:     cfg_d.unlock_level     = cfg_data_i;
        CFG_EDGE_FLOOR:       cfg_d.edge_floor       = cfg_data_i;
        CFG_TRUST_FLOOR:      cfg_d.trust_floor      = cfg_data_i;
        CFG_CHANGE_CEILING:   cfg_d.change_ceiling   = cfg_data_i;
        CFG_MOTION_CEILING:   cfg_d.motion_ceiling   = cfg_data_i;
        CFG_FADE_STEP:        cfg_d.fade_step        = cfg_data_i;
        CFG_FORCED_FADE_STEP: cfg_d.forced_fade_step = cfg_data_i;
        CFG_GROW_STEP:        cfg_d.grow_step        = cfg_data_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unlock_level     <= 16'd16384;
      cfg_q.edge_floor       <= 16'd3277;
      cfg_q.trust_floor      <= 16'd16384;
      cfg_q.change_ceiling   <= 16'd3277;
      cfg_q.motion_ceiling   <= 16'd512;
      cfg_q.fade_step        <= 16'd8192;
      cfg_q.forced_fade_step <= 16'd32768;
      cfg_q.grow_step        <= 16'd8192;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/pflu_calc.sv
// ----------------------------------------------------------------------------
// pflu_calc
// Lock decision and level/count update; one shared 16x16 multiplier serves
// both the fade and the grow path.
// ----------------------------------------------------------------------------
module pflu_calc import pflu_pkg::*; (
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  logic [LvlW-1:0]   change_abs, motion_abs;
  logic              forced, stable, grow;
  logic [LvlW-1:0]   step_cl, keep, rate_cl, gap;
  logic [LvlW-1:0]   mul_a, mul_b;
  logic [2*LvlW-1:0] prod;
  logic [LvlW:0]     prod_sh;
  logic [LvlW-1:0]   fade_level, grow_level;
  logic [LvlW-1:0]   grow_count;

  // |x| of a 16-bit two's complement value; -32768 maps to 32768
  assign change_abs = item_i.brightness_change[LvlW-1] ?
                      (LvlW)'(-item_i.brightness_change) : item_i.brightness_change;
  assign motion_abs = item_i.motion_amount[LvlW-1] ?
                      (LvlW)'(-item_i.motion_amount) : item_i.motion_amount;

  assign forced = item_i.newly_uncovered || (item_i.reactivity >= cfg_i.unlock_level);
  assign stable = (item_i.edge_level >= cfg_i.edge_floor) &&
                  (item_i.trust_level >= cfg_i.trust_floor) &&
                  (change_abs <= cfg_i.change_ceiling) &&
                  (item_i.brightness_spread <= SPREAD_CEILING) &&
                  (motion_abs <= cfg_i.motion_ceiling);
  assign grow   = !forced && stable;

  assign step_cl = clamp_one(forced ? cfg_i.forced_fade_step : cfg_i.fade_step);
  assign keep    = ONE_Q15 - step_cl;
  assign rate_cl = clamp_one((item_i.prior_lock != '0) ? cfg_i.grow_step : FIRST_GROW_STEP);
  assign gap     = ONE_Q15 - item_i.prior_lock;  // only used while prior < 1.0

  assign mul_a   = grow ? gap : item_i.prior_lock;
  assign mul_b   = grow ? rate_cl : keep;
  assign prod    = mul_a * mul_b;
  assign prod_sh = prod[2*LvlW-1:LvlW-1];

  assign fade_level = (prod_sh > {1'b0, ONE_Q15}) ? ONE_Q15 : prod_sh[LvlW-1:0];
  assign grow_level = (item_i.prior_lock >= ONE_Q15) ? ONE_Q15 :
                      item_i.prior_lock + prod_sh[LvlW-1:0];
  assign grow_count = (item_i.prior_count >= COUNT_LIMIT) ? COUNT_LIMIT :
                      item_i.prior_count + 16'd1;

  always_comb begin
    if (item_i.clear_history) begin
      res_o.lock_level = '0;
      res_o.lock_count = '0;
    end else if (grow) begin
      res_o.lock_level = grow_level;
      res_o.lock_count = grow_count;
    end else begin
      res_o.lock_level = fade_level;
      res_o.lock_count = (fade_level >= KEEP_MIN) ? item_i.prior_count : '0;
    end
  end

endmodule

>>> sv/pixel_feature_lock_update.sv
// ----------------------------------------------------------------------------
// pixel_feature_lock_update
// Per-pixel feature lock level and age update on a streaming interface.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_axis    in         s_axis_tvalid/tready   tuser: flags, tdata: measures
//  m_axis    out        m_axis_tvalid/tready   tdata: lock level, lock count
//  cfg       in         cfg_we_i               cfg_idx_i, cfg_data_i
//
//  One pixel per clock while m_axis_tready keeps up; an accepted beat passes
//  the input register, then the result register, before it shows on m_axis.
//  The single update stage uses one shared combinational multiplier.
//  m_axis_tready low with a result waiting stalls both stages; s_axis_tready
//  falls only when both registers hold data and m_axis_tready is low.
//  rst_ni clears the valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
module pixel_feature_lock_update import pflu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // reactivity, prior_lock, prior_count, edge_level, trust_level,
  // brightness_change, brightness_spread, motion_amount (16 b each, low first)
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // clear_history, newly_uncovered (low first)
  input  logic [InUserW-1:0]  s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // lock_level, lock_count (low first)
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [LvlW-1:0]     cfg_data_i
);

  cfg_t  cfg;
  item_t in_item;
  item_t s1_item_q, s1_item_d;
  logic  s1_valid_q, s1_valid_d;
  res_t  res;
  res_t  out_res_q, out_res_d;
  logic  out_valid_q, out_valid_d;
  logic  out_adv, in_acc;

  pflu_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign in_item.clear_history     = s_axis_tuser_i[0];
  assign in_item.newly_uncovered   = s_axis_tuser_i[1];
  assign in_item.reactivity        = s_axis_tdata_i[15:0];
  assign in_item.prior_lock        = s_axis_tdata_i[31:16];
  assign in_item.prior_count       = s_axis_tdata_i[47:32];
  assign in_item.edge_level        = s_axis_tdata_i[63:48];
  assign in_item.trust_level       = s_axis_tdata_i[79:64];
  assign in_item.brightness_change = s_axis_tdata_i[95:80];
  assign in_item.brightness_spread = s_axis_tdata_i[111:96];
  assign in_item.motion_amount     = s_axis_tdata_i[127:112];

  assign out_adv         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || out_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_item_d  = s1_item_q;
    if (s_axis_tready_o) begin
      s1_valid_d = s_axis_tvalid_i;
    end
    if (in_acc) begin
      s1_item_d = in_item;
    end
  end

  pflu_calc u_calc (
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (out_adv) begin
      out_valid_d = s1_valid_q;
      if (s1_valid_q) begin
        out_res_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q <= s1_item_d;
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_res_q.lock_count, out_res_q.lock_level};

`ifndef ASSERT_OFF
  a_clear_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_adv && s1_item_q.clear_history |=> m_axis_tdata_o == '0)
    else $error("clear request did not give a zero result");

  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> out_res_q.lock_level <= ONE_Q15)
    else $error("lock level above 1.0");

  a_ready_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready_o)
    else $error("input stalled while result register is free");

  a_stage_moves_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_adv |=> m_axis_tvalid_o)
    else $error("staged beat lost on the way to the output");
`endif

endmodule

>>> tb/sv/pflu_lock_checker.sv
// ----------------------------------------------------------------------------
// pflu_lock_checker
// Watches the pixel and result streams and the register port of the lock
// update block. Computes the expected lock level and count of every pixel
// beat it sees accepted, queues them, and compares each result beat with the
// oldest entry. The failure count and the number of results still due go
// back to the testbench top.
// ----------------------------------------------------------------------------
module pflu_lock_checker import pflu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic [InUserW-1:0]  s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [LvlW-1:0]     cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] Q15 = 32'd32768;

  cfg_t cfg;
  res_t lock_q[$];
  int   n_results;

  function automatic logic [31:0] sat_q15(input logic [31:0] v);
    return (v > Q15) ? Q15 : v;
  endfunction

  // |v| of a 16-bit two's complement value; -32768 gives 32768
  function automatic logic [31:0] mag16(input logic [15:0] v);
    return v[15] ? (32'h10000 - {16'h0, v}) : {16'h0, v};
  endfunction

  function automatic logic [31:0] fade_level(input logic [15:0] lvl, input logic [15:0] step);
    logic [31:0] keep;
    keep = Q15 - sat_q15({16'h0, step});
    return sat_q15(({16'h0, lvl} * keep) >> 15);
  endfunction

  function automatic res_t lock_update(input item_t px, input cfg_t c);
    res_t        r;
    logic [31:0] lvl;
    logic [31:0] cnt;
    logic [31:0] rate;
    logic        stable;
    stable = px.edge_level >= c.edge_floor && px.trust_level >= c.trust_floor &&
             mag16(px.brightness_change) <= {16'h0, c.change_ceiling} &&
             px.brightness_spread <= SPREAD_CEILING &&
             mag16(px.motion_amount) <= {16'h0, c.motion_ceiling};
    if (px.clear_history) begin
      lvl = '0;
      cnt = '0;
    end else if (px.newly_uncovered || px.reactivity >= c.unlock_level) begin
      lvl = fade_level(px.prior_lock, c.forced_fade_step);
      cnt = (lvl >= {16'h0, KEEP_MIN}) ? {16'h0, px.prior_count} : '0;
    end else if (!stable) begin
      lvl = fade_level(px.prior_lock, c.fade_step);
      cnt = (lvl >= {16'h0, KEEP_MIN}) ? {16'h0, px.prior_count} : '0;
    end else begin
      // first growth from zero uses the fixed rate
      rate = sat_q15({16'h0, (px.prior_lock != '0) ? c.grow_step : FIRST_GROW_STEP});
      if ({16'h0, px.prior_lock} >= Q15) begin
        lvl = Q15;
      end else begin
        lvl = {16'h0, px.prior_lock} + (((Q15 - {16'h0, px.prior_lock}) * rate) >> 15);
      end
      cnt = {16'h0, px.prior_count} + 32'd1;
      if (cnt > {16'h0, COUNT_LIMIT}) begin
        cnt = {16'h0, COUNT_LIMIT};
      end
    end
    r.lock_level = lvl[15:0];
    r.lock_count = cnt[15:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    item_t       px;
    res_t        want;
    logic [15:0] got_level;
    logic [15:0] got_count;
    if (!rst_ni) begin
      cfg = '{unlock_level: 16'd16384, edge_floor: 16'd3277, trust_floor: 16'd16384,
              change_ceiling: 16'd3277, motion_ceiling: 16'd512, fade_step: 16'd8192,
              forced_fade_step: 16'd32768, grow_step: 16'd8192};
      lock_q.delete();
      fail_count_o = 0;
      n_results = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_UNLOCK_LEVEL:     cfg.unlock_level     = cfg_data_i;
          CFG_EDGE_FLOOR:       cfg.edge_floor       = cfg_data_i;
          CFG_TRUST_FLOOR:      cfg.trust_floor      = cfg_data_i;
          CFG_CHANGE_CEILING:   cfg.change_ceiling   = cfg_data_i;
          CFG_MOTION_CEILING:   cfg.motion_ceiling   = cfg_data_i;
          CFG_FADE_STEP:        cfg.fade_step        = cfg_data_i;
          CFG_FORCED_FADE_STEP: cfg.forced_fade_step = cfg_data_i;
          CFG_GROW_STEP:        cfg.grow_step        = cfg_data_i;
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got_level = m_tdata_i[15:0];
        got_count = m_tdata_i[31:16];
        if (lock_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("unexpected result beat %0d: level %0d count %0d",
                     n_results, got_level, got_count);
          end
        end else begin
          want = lock_q.pop_front();
          if (want.lock_level !== got_level || want.lock_count !== got_count) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("result %0d: expected level %0d count %0d, got level %0d count %0d",
                       n_results, want.lock_level, want.lock_count, got_level, got_count);
            end
          end
        end
        n_results++;
      end
      if (s_tvalid_i && s_tready_i) begin
        px.clear_history     = s_tuser_i[0];
        px.newly_uncovered   = s_tuser_i[1];
        px.reactivity        = s_tdata_i[15:0];
        px.prior_lock        = s_tdata_i[31:16];
        px.prior_count       = s_tdata_i[47:32];
        px.edge_level        = s_tdata_i[63:48];
        px.trust_level       = s_tdata_i[79:64];
        px.brightness_change = s_tdata_i[95:80];
        px.brightness_spread = s_tdata_i[111:96];
        px.motion_amount     = s_tdata_i[127:112];
        lock_q.push_back(lock_update(px, cfg));
      end
    end
    pending_o = lock_q.size();
  end

endmodule

>>> tb/sv/pixel_feature_lock_update_test.sv
// ----------------------------------------------------------------------------
// pixel_feature_lock_update_test
// Stimulus and verdict for the pixel feature lock update block. A directed
// set of pixels at the reset register values covers every update path and
// its boundaries; then several register settings, extremes included, each
// get a batch of shaped random pixels. Both stream sides idle at random, the
// result side holds off once for a long stretch, and the checker beside the
// block does all prediction and comparison.
// ----------------------------------------------------------------------------
module pixel_feature_lock_update_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pflu_pkg::*;

  localparam int NumPhases    = 7;
  localparam int PhaseBeats   = 255;
  localparam int HoldAt       = 500;
  localparam int HoldCycles   = 80;
  localparam int CycleLimit   = 100000;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [InUserW-1:0]  s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [LvlW-1:0]     cfg_data = '0;

  logic steady = 1'b0;
  logic held = 1'b0;
  int   hold_left = 0;
  int   sent = 0;
  int   fails;
  int   pending;
  cfg_t cur_cfg;

  pixel_feature_lock_update uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  pflu_lock_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stalls, one long hold-off while pixels keep coming
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held && sent >= HoldAt) begin
      held <= 1'b1;
      hold_left <= HoldCycles;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 8);
    end
  end

  function automatic item_t pix(input logic clr, input logic unc, input int react,
                                input int prior, input int cnt, input int edge_l,
                                input int trust, input int chg, input int spread,
                                input int mot);
    item_t px;
    px.clear_history     = clr;
    px.newly_uncovered   = unc;
    px.reactivity        = 16'(react);
    px.prior_lock        = 16'(prior);
    px.prior_count       = 16'(cnt);
    px.edge_level        = 16'(edge_l);
    px.trust_level       = 16'(trust);
    px.brightness_change = 16'(chg);
    px.brightness_spread = 16'(spread);
    px.motion_amount     = 16'(mot);
    return px;
  endfunction

  // signed value with magnitude in [lo, hi], hi at most 32768
  function automatic logic [15:0] signed_mag(input int unsigned lo, input int unsigned hi);
    int unsigned mag;
    mag = $urandom_range(hi, lo);
    return $urandom_range(1) ? 16'(-int'(mag)) : 16'(mag);
  endfunction

  function automatic logic [15:0] cfg_value();
    int pick;
    pick = $urandom_range(19);
    if (pick < 14) return 16'($urandom_range(32768));
    if (pick < 16) return 16'd0;
    if (pick < 18) return ONE_Q15;
    return 16'($urandom_range(65535));
  endfunction

  // mostly pixels that pass the stability tests, then broken ones,
  // forced fades and plain noise
  function automatic item_t rand_pixel(input cfg_t c);
    item_t       px;
    int          kind;
    int          pick;
    int unsigned chg_ceil;
    int unsigned mot_ceil;
    chg_ceil = (c.change_ceiling > ONE_Q15) ? 32768 : c.change_ceiling;
    mot_ceil = (c.motion_ceiling > ONE_Q15) ? 32768 : c.motion_ceiling;
    px.clear_history     = 1'b0;
    px.newly_uncovered   = 1'b0;
    px.reactivity        = (c.unlock_level == '0) ? 16'd0 :
                           16'($urandom_range(int'(c.unlock_level) - 1));
    px.edge_level        = 16'($urandom_range(65535, c.edge_floor));
    px.trust_level       = 16'($urandom_range(65535, c.trust_floor));
    px.brightness_change = signed_mag(0, chg_ceil);
    px.brightness_spread = 16'($urandom_range(SPREAD_CEILING));
    px.motion_amount     = signed_mag(0, mot_ceil);
    pick = $urandom_range(9);
    if (pick < 6)       px.prior_lock = 16'($urandom_range(32768));
    else if (pick == 6) px.prior_lock = 16'd0;
    else if (pick == 7) px.prior_lock = ONE_Q15;
    else if (pick == 8) px.prior_lock = 16'($urandom_range(65535, 32769));
    else                px.prior_lock = 16'($urandom_range(60, 20));
    pick = $urandom_range(9);
    if (pick < 6)       px.prior_count = 16'($urandom_range(300));
    else if (pick < 8)  px.prior_count = 16'($urandom_range(65535));
    else if (pick == 8) px.prior_count = 16'($urandom_range(256, 250));
    else                px.prior_count = 16'hFFFF;
    kind = $urandom_range(99);
    if (kind < 20) begin
      case ($urandom_range(4))
        0: if (c.edge_floor != '0)
             px.edge_level = 16'($urandom_range(int'(c.edge_floor) - 1));
        1: if (c.trust_floor != '0)
             px.trust_level = 16'($urandom_range(int'(c.trust_floor) - 1));
        2: if (chg_ceil < 32768) px.brightness_change = signed_mag(chg_ceil + 1, 32768);
        3: px.brightness_spread = 16'($urandom_range(65535, int'(SPREAD_CEILING) + 1));
        default: if (mot_ceil < 32768) px.motion_amount = signed_mag(mot_ceil + 1, 32768);
      endcase
    end else if (kind < 33) begin
      px.newly_uncovered = 1'($urandom_range(1));
      if (!px.newly_uncovered || $urandom_range(1)) begin
        px.reactivity = 16'($urandom_range(65535, c.unlock_level));
      end
    end else if (kind < 45) begin
      px.clear_history     = 1'($urandom_range(1));
      px.newly_uncovered   = 1'($urandom_range(1));
      px.reactivity        = 16'($urandom);
      px.prior_lock        = 16'($urandom);
      px.prior_count       = 16'($urandom);
      px.edge_level        = 16'($urandom);
      px.trust_level       = 16'($urandom);
      px.brightness_change = 16'($urandom);
      px.brightness_spread = 16'($urandom);
      px.motion_amount     = 16'($urandom);
    end
    if ($urandom_range(99) < 3) px.clear_history = 1'b1;
    return px;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_pixel(input item_t px);
    while (!steady && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {px.newly_uncovered, px.clear_history};
    s_tdata  <= {px.motion_amount, px.brightness_spread, px.brightness_change,
                 px.trust_level, px.edge_level, px.prior_count, px.prior_lock,
                 px.reactivity};
    do @(posedge clk_i); while (!s_tready);
    sent++;
    @(negedge clk_i);
  endtask

  // wait for every result to leave the two-stage pipeline, then some margin
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [LvlW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
  endtask

  initial begin
    cfg_t c;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset registers: unlock 0.5, edge 0.1, trust 0.5, change 0.1, motion 2 px
    send_pixel(pix(1, 1, 65535, 65535, 65535, 65535, 65535, -32768, 65535, -32768));
    send_pixel(pix(1, 0, 0, 20000, 100, 16000, 20000, 0, 0, 0));
    send_pixel(pix(0, 1, 0, 32768, 77, 16000, 20000, 0, 0, 0));
    send_pixel(pix(0, 1, 0, 65535, 77, 16000, 20000, 0, 0, 0));
    send_pixel(pix(0, 0, 16384, 20000, 9, 16000, 20000, 0, 0, 0));
    send_pixel(pix(0, 0, 16383, 20000, 9, 16000, 20000, 0, 0, 0));
    send_pixel(pix(0, 0, 0, 0, 0, 16000, 20000, 0, 0, 0));
    send_pixel(pix(0, 0, 0, 32768, 254, 16000, 20000, 0, 0, 0));
    send_pixel(pix(0, 0, 0, 40000, 255, 16000, 20000, 0, 0, 0));
    send_pixel(pix(0, 0, 0, 100, 65535, 16000, 20000, 0, 0, 0));
    send_pixel(pix(0, 0, 0, 20000, 5, 3276, 20000, 0, 0, 0));
    send_pixel(pix(0, 0, 0, 20000, 5, 3277, 16384, 0, 0, 0));
    send_pixel(pix(0, 0, 0, 20000, 5, 16000, 16383, 0, 0, 0));
    send_pixel(pix(0, 0, 0, 20000, 5, 16000, 20000, 3278, 0, 0));
    send_pixel(pix(0, 0, 0, 20000, 5, 16000, 20000, -3278, 0, 0));
    send_pixel(pix(0, 0, 0, 20000, 5, 16000, 20000, -3277, 0, 0));
    send_pixel(pix(0, 0, 0, 20000, 5, 16000, 20000, -32768, 0, 0));
    send_pixel(pix(0, 0, 0, 20000, 5, 16000, 20000, 3277, 3278, 0));
    send_pixel(pix(0, 0, 0, 20000, 5, 16000, 20000, 0, 3277, 513));
    send_pixel(pix(0, 0, 0, 20000, 5, 16000, 20000, 0, 0, -512));
    send_pixel(pix(0, 0, 0, 20000, 5, 16000, 20000, 0, 0, -32768));
    // fade to just above and just below 0.001 keeps or drops the count
    send_pixel(pix(0, 0, 0, 44, 500, 0, 20000, 0, 0, 0));
    send_pixel(pix(0, 0, 0, 43, 500, 0, 20000, 0, 0, 0));
    send_pixel(pix(0, 0, 0, 65535, 1, 0, 20000, 0, 0, 0));

    for (int ph = 1; ph <= NumPhases; ph++) begin
      drain();
      case (ph)
        1: c = '{unlock_level: ONE_Q15, edge_floor: 16'd0, trust_floor: 16'd0,
                 change_ceiling: ONE_Q15, motion_ceiling: ONE_Q15, fade_step: 16'd0,
                 forced_fade_step: 16'd0, grow_step: ONE_Q15};
        2: c = '{unlock_level: 16'hFFFF, edge_floor: ONE_Q15, trust_floor: ONE_Q15,
                 change_ceiling: 16'd0, motion_ceiling: 16'd0, fade_step: 16'hFFFF,
                 forced_fade_step: 16'hFFFF, grow_step: 16'd0};
        default: begin
          c.unlock_level     = cfg_value();
          c.edge_floor       = cfg_value();
          c.trust_floor      = cfg_value();
          c.change_ceiling   = cfg_value();
          c.motion_ceiling   = cfg_value();
          c.fade_step        = cfg_value();
          c.forced_fade_step = cfg_value();
          c.grow_step        = cfg_value();
        end
      endcase
      write_reg(CFG_UNLOCK_LEVEL, c.unlock_level);
      write_reg(CFG_EDGE_FLOOR, c.edge_floor);
      write_reg(CFG_TRUST_FLOOR, c.trust_floor);
      write_reg(CFG_CHANGE_CEILING, c.change_ceiling);
      write_reg(CFG_MOTION_CEILING, c.motion_ceiling);
      write_reg(CFG_FADE_STEP, c.fade_step);
      write_reg(CFG_FORCED_FADE_STEP, c.forced_fade_step);
      write_reg(CFG_GROW_STEP, c.grow_step);
      cfg_we <= 1'b0;
      cur_cfg = c;
      steady <= (ph == 3);
      for (int k = 0; k < PhaseBeats; k++) begin
        send_pixel(rand_pixel(cur_cfg));
      end
    end

    drain();
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> pixel_feature_lock_update.f
sv/pflu_pkg.sv
sv/pflu_cfg_regs.sv
sv/pflu_calc.sv
sv/pixel_feature_lock_update.sv
tb/sv/pflu_lock_checker.sv
tb/sv/pixel_feature_lock_update_test.sv
